@@ hw/rtl/ipsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ipsd_pkg
// shared constants, payload types and the sine/cosine tables of the
// inverse park / space vector duty pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipsd_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int DIFF_W  = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
    localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int K_W     = $clog2(SINE_TABLE_DEPTH);
    localparam int KPROD_W = ANGLE_BITS + DEPTH_W;
    localparam int P_W     = 20;
    localparam int SQ_W    = 31;

    typedef logic signed [15:0] q15_t;
    typedef logic [15:0]        u16_t;
    typedef logic [2:0]         sector_t;
    typedef logic signed [P_W-1:0] p_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [ANGLE_BITS-1:0] angle_t;
    typedef logic [K_W-1:0]     k_t;

    localparam sector_t SECTOR_1 = 3'd1;
    localparam sector_t SECTOR_2 = 3'd2;
    localparam sector_t SECTOR_3 = 3'd3;
    localparam sector_t SECTOR_4 = 3'd4;
    localparam sector_t SECTOR_5 = 3'd5;
    localparam sector_t SECTOR_6 = 3'd6;

    typedef struct packed {
        q15_t q_reference;
        u16_t target_angle;
        u16_t rotor_angle;
    } cmd_t;

    typedef struct packed {
        q15_t q;
        q15_t sin;
        q15_t cos;
    } trig_t;

    typedef struct packed {
        q15_t alpha;
        q15_t beta;
        p_t   bs;
        p_t   b2;
        sq_t  alpha_sq;
        sq_t  beta_sq;
    } park_t;

    typedef struct packed {
        u16_t    duty_a;
        u16_t    duty_b;
        u16_t    duty_c;
        sector_t sector;
        q15_t    v_alpha;
        q15_t    v_beta;
    } res_t;

    typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    function automatic longint quarter_poly(input longint z);
        longint z2;
        longint t;
        z2 = (z * z) >>> 16;
        t  = (5223 * z2) >>> 16;
        t  = ((42334 - t) * z2) >>> 16;
        t  = ((102944 - t) * z) >>> 17;
        if (t < 0)
            t = 0;
        if (t > 32767)
            t = 32767;
        return t;
    endfunction

    function automatic sine_rom_t build_rom(input int quad_shift);
        sine_rom_t rom;
        longint p;
        longint quad;
        longint r;
        longint z;
        longint v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            p    = 4 * longint'(k);
            quad = (p / SINE_TABLE_DEPTH + longint'(quad_shift)) & 3;
            r    = p % SINE_TABLE_DEPTH;
            z    = (r << 16) / SINE_TABLE_DEPTH;
            if ((quad & 1) != 0)
                z = 65536 - z;
            v = quarter_poly(z);
            if ((quad & 2) != 0)
                v = -v;
            rom[k] = 16'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom(0);
    localparam sine_rom_t COS_ROM  = build_rom(1);

endpackage

@@ hw/rtl/ipsd_cmd_if.sv @@
// ----------------------------------------------------------------------------
// ipsd_cmd_if
// command channel: q reference and the two electrical angles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipsd_cmd_if import ipsd_pkg::*; ();

    logic valid;
    logic ready;
    q15_t q_reference;
    u16_t target_angle;
    u16_t rotor_angle;

    modport source (output valid, output q_reference, output target_angle,
                    output rotor_angle, input ready);
    modport sink (input valid, input q_reference, input target_angle,
                  input rotor_angle, output ready);

endinterface

@@ hw/rtl/ipsd_res_if.sv @@
// ----------------------------------------------------------------------------
// ipsd_res_if
// result channel: three phase duties, sector and alpha/beta voltages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipsd_res_if import ipsd_pkg::*; ();

    logic    valid;
    logic    ready;
    u16_t    duty_a;
    u16_t    duty_b;
    u16_t    duty_c;
    sector_t sector;
    q15_t    v_alpha;
    q15_t    v_beta;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output sector, output v_alpha, output v_beta, input ready);
    modport sink (input valid, input duty_a, input duty_b, input duty_c,
                  input sector, input v_alpha, input v_beta, output ready);

endinterface

@@ hw/rtl/ipsd_angle_lookup.sv @@
// ----------------------------------------------------------------------------
// ipsd_angle_lookup
// three stages: wrapped angle difference, table index, sine/cosine lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipsd_angle_lookup import ipsd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_ready,
    input  cmd_t  cmd,
    output logic  trig_valid,
    input  logic  trig_ready,
    output trig_t trig
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    angle_t theta_reg, theta_next;
    q15_t   q1_reg;
    k_t     k_reg, k_next;
    q15_t   q2_reg;
    trig_t  trig_reg, trig_next;

    logic [DIFF_W-1:0]  diff;
    logic [KPROD_W-1:0] kprod;

    assign adv3      = !v3_reg || trig_ready;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign cmd_ready = adv1;

    always_comb
    begin
        diff       = DIFF_W'(cmd.target_angle) - DIFF_W'(cmd.rotor_angle);
        theta_next = diff[ANGLE_BITS-1:0];
        kprod      = KPROD_W'(theta_reg) * KPROD_W'(SINE_TABLE_DEPTH);
        k_next     = kprod[ANGLE_BITS +: K_W];
        trig_next.q   = q2_reg;
        trig_next.sin = SINE_ROM[k_reg];
        trig_next.cos = COS_ROM[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= cmd_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && cmd_valid)
        begin
            theta_reg <= theta_next;
            q1_reg    <= cmd.q_reference;
        end
        if (adv2 && v1_reg)
        begin
            k_reg  <= k_next;
            q2_reg <= q1_reg;
        end
        if (adv3 && v2_reg)
            trig_reg <= trig_next;
    end

    assign trig_valid = v3_reg;
    assign trig       = trig_reg;

endmodule

@@ hw/rtl/ipsd_park.sv @@
// ----------------------------------------------------------------------------
// ipsd_park
// two stages: inverse park with d = 0, then beta scaling and squares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipsd_park import ipsd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  trig_valid,
    output logic  trig_ready,
    input  trig_t trig,
    output logic  park_valid,
    input  logic  park_ready,
    output park_t park
);

    localparam logic signed [32:0] RND15 = 33'sd16384;
    localparam logic signed [34:0] RND16 = 35'sd32768;
    localparam logic signed [34:0] INV_SQRT3_Q16     = 35'sd37837;
    localparam logic signed [34:0] TWO_INV_SQRT3_Q16 = 35'sd75674;

    logic v1_reg, v2_reg;
    logic adv1, adv2;

    q15_t  alpha_reg, alpha_next;
    q15_t  beta_reg, beta_next;
    park_t park_reg, park_next;

    logic signed [32:0] prod_a, prod_b, shf_a, shf_b;
    logic signed [34:0] bs_full, b2_full, bs_shf, b2_shf;
    logic signed [31:0] asq_full, bsq_full;

    function automatic q15_t sat_q15(input logic signed [32:0] v);
        if (v > 33'sd32767)
            return 16'sh7fff;
        if (v < -33'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    assign adv2       = !v2_reg || park_ready;
    assign adv1       = !v1_reg || adv2;
    assign trig_ready = adv1;

    always_comb
    begin
        prod_a     = -(33'(trig.q) * 33'(trig.sin));
        prod_b     = 33'(trig.q) * 33'(trig.cos);
        shf_a      = (prod_a + RND15) >>> 15;
        shf_b      = (prod_b + RND15) >>> 15;
        alpha_next = sat_q15(shf_a);
        beta_next  = sat_q15(shf_b);

        bs_full  = 35'(beta_reg) * INV_SQRT3_Q16;
        b2_full  = 35'(beta_reg) * TWO_INV_SQRT3_Q16;
        bs_shf   = (bs_full + RND16) >>> 16;
        b2_shf   = (b2_full + RND16) >>> 16;
        asq_full = 32'(alpha_reg) * 32'(alpha_reg);
        bsq_full = 32'(beta_reg) * 32'(beta_reg);

        park_next.alpha    = alpha_reg;
        park_next.beta     = beta_reg;
        park_next.bs       = bs_shf[P_W-1:0];
        park_next.b2       = b2_shf[P_W-1:0];
        park_next.alpha_sq = asq_full[SQ_W-1:0];
        park_next.beta_sq  = bsq_full[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= trig_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && trig_valid)
        begin
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
        end
        if (adv2 && v1_reg)
            park_reg <= park_next;
    end

    assign park_valid = v2_reg;
    assign park       = park_reg;

endmodule

@@ hw/rtl/ipsd_svm.sv @@
// ----------------------------------------------------------------------------
// ipsd_svm
// two stages: sector decision with p1/p2 selection, then saturated duties
// and the phase mapping of the sector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipsd_svm import ipsd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  park_valid,
    output logic  park_ready,
    input  park_t park,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam int SUM_W = P_W + 2;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(32768);

    logic v1_reg, v2_reg;
    logic adv1, adv2;

    sector_t sector_reg, sector_next;
    p_t      p1_reg, p1_next;
    p_t      p2_reg, p2_next;
    q15_t    alpha_reg, beta_reg;
    res_t    res_reg, res_next;

    p_t                 alpha_p, bs, b2;
    logic [32:0]        a3;
    logic               steep, upper, alpha_pos;
    logic signed [SUM_W-1:0] sum3, sum2, sum1;
    u16_t               c3, c2, c1;

    function automatic u16_t sat_duty(input logic signed [SUM_W-1:0] v);
        if (v < 0)
            return 16'h0000;
        if (v > SUM_W'(65535))
            return 16'hffff;
        return v[15:0];
    endfunction

    assign adv2       = !v2_reg || res_ready;
    assign adv1       = !v1_reg || adv2;
    assign park_ready = adv1;

    always_comb
    begin
        alpha_p   = P_W'(park.alpha);
        bs        = park.bs;
        b2        = park.b2;
        a3        = 33'(park.alpha_sq) + 33'({park.alpha_sq, 1'b0});
        steep     = 33'(park.beta_sq) > a3;
        upper     = park.beta > 16'sd0;
        alpha_pos = park.alpha > 16'sd0;

        if (upper)
        begin
            if (steep)
            begin
                sector_next = SECTOR_2;
                p1_next     = bs + alpha_p;
                p2_next     = bs - alpha_p;
            end
            else if (alpha_pos)
            begin
                sector_next = SECTOR_1;
                p1_next     = b2;
                p2_next     = alpha_p - bs;
            end
            else
            begin
                sector_next = SECTOR_3;
                p1_next     = -bs - alpha_p;
                p2_next     = b2;
            end
        end
        else
        begin
            if (steep)
            begin
                sector_next = SECTOR_5;
                p1_next     = alpha_p - bs;
                p2_next     = -bs - alpha_p;
            end
            else if (alpha_pos)
            begin
                sector_next = SECTOR_6;
                p1_next     = -b2;
                p2_next     = alpha_p + bs;
            end
            else
            begin
                sector_next = SECTOR_4;
                p1_next     = bs - alpha_p;
                p2_next     = -b2;
            end
        end

        sum3 = HALF - SUM_W'(p1_reg) - SUM_W'(p2_reg);
        sum2 = HALF + SUM_W'(p1_reg) - SUM_W'(p2_reg);
        sum1 = HALF + SUM_W'(p1_reg) + SUM_W'(p2_reg);
        c3   = sat_duty(sum3);
        c2   = sat_duty(sum2);
        c1   = sat_duty(sum1);

        res_next.sector  = sector_reg;
        res_next.v_alpha = alpha_reg;
        res_next.v_beta  = beta_reg;
        case (sector_reg)
            SECTOR_1:
            begin
                res_next.duty_a = c1;
                res_next.duty_b = c2;
                res_next.duty_c = c3;
            end
            SECTOR_2:
            begin
                res_next.duty_a = c2;
                res_next.duty_b = c1;
                res_next.duty_c = c3;
            end
            SECTOR_3:
            begin
                res_next.duty_a = c3;
                res_next.duty_b = c1;
                res_next.duty_c = c2;
            end
            SECTOR_5:
            begin
                res_next.duty_a = c2;
                res_next.duty_b = c3;
                res_next.duty_c = c1;
            end
            SECTOR_6:
            begin
                res_next.duty_a = c1;
                res_next.duty_b = c3;
                res_next.duty_c = c2;
            end
            default:
            begin
                res_next.duty_a = c3;
                res_next.duty_b = c2;
                res_next.duty_c = c1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= park_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && park_valid)
        begin
            sector_reg <= sector_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            alpha_reg  <= park.alpha;
            beta_reg   <= park.beta;
        end
        if (adv2 && v1_reg)
            res_reg <= res_next;
    end

    assign res_valid = v2_reg;
    assign res       = res_reg;

    // upper half sectors exactly when beta is positive
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.sector == SECTOR_1 || res.sector == SECTOR_2 ||
                        res.sector == SECTOR_3) == (res.v_beta > 16'sd0)))
        else $error("sector half does not match sign of beta");

    // side sectors on the right need positive alpha
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.sector == SECTOR_1 || res.sector == SECTOR_6)
        |-> res.v_alpha > 16'sd0)
        else $error("right side sector with non-positive alpha");

    // zero vector gives sector 4 and half duty on all phases
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.v_alpha == 16'sd0 && res.v_beta == 16'sd0
        |-> res.sector == SECTOR_4 && res.duty_a == 16'h8000 &&
            res.duty_b == 16'h8000 && res.duty_c == 16'h8000)
        else $error("zero vector gives wrong sector or duty");

    // a word leaving the first stage always lands in the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && adv2 |=> res_valid)
        else $error("word lost between svm stages");

endmodule

@@ hw/rtl/inverse_park_svpwm_duty.sv @@
// ----------------------------------------------------------------------------
// inverse_park_svpwm_duty
// register stages from command accept to result valid (angle diff, table
// index, sin/cos rom, park, scaling, sector, duty). throughput: one word
// per cycle while results are taken; every stage advances when its successor
// has room, so bubbles close up while a result waits on the output
// reset: clears the stage valid bits only, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverse_park_svpwm_duty import ipsd_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    ipsd_cmd_if.sink   request,
    ipsd_res_if.source result
);

    cmd_t  cmd;
    trig_t trig;
    park_t park;
    res_t  res;
    logic  trig_valid, trig_ready;
    logic  park_valid, park_ready;
    logic  res_valid;

    assign cmd.q_reference  = request.q_reference;
    assign cmd.target_angle = request.target_angle;
    assign cmd.rotor_angle  = request.rotor_angle;

    ipsd_angle_lookup u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (request.valid),
        .cmd_ready  (request.ready),
        .cmd        (cmd),
        .trig_valid (trig_valid),
        .trig_ready (trig_ready),
        .trig       (trig)
    );

    ipsd_park u_park (
        .clk        (clk),
        .rst_n      (rst_n),
        .trig_valid (trig_valid),
        .trig_ready (trig_ready),
        .trig       (trig),
        .park_valid (park_valid),
        .park_ready (park_ready),
        .park       (park)
    );

    ipsd_svm u_svm (
        .clk        (clk),
        .rst_n      (rst_n),
        .park_valid (park_valid),
        .park_ready (park_ready),
        .park       (park),
        .res_valid  (res_valid),
        .res_ready  (result.ready),
        .res        (res)
    );

    assign result.valid   = res_valid;
    assign result.duty_a  = res.duty_a;
    assign result.duty_b  = res.duty_b;
    assign result.duty_c  = res.duty_c;
    assign result.sector  = res.sector;
    assign result.v_alpha = res.v_alpha;
    assign result.v_beta  = res.v_beta;

endmodule
